@@ rtl/ntt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg: shared types and constants of the NAPT translation table
// Holds the field codes, the table entry layouts and the command and status
// records that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int MAP_ENTRIES_DEF  = 256;
  localparam int RULE_ENTRIES_DEF = 8;

  localparam int BM_WORD_W = 32;
  localparam int BM_BIT_W  = 5;
  localparam int BM_ADDR_W = 11;
  localparam int BM_WORDS  = 2048;

  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd60;
  localparam logic [15:0] FIRST_PORT_RESET = 16'd1024;
  localparam logic [15:0] LAST_PORT_RESET  = 16'hFFFF;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_RST = 8'h04;

  localparam logic [1:0] ACT_PACKET = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_RULE   = 2'd2;

  localparam logic [1:0] DIR_IN  = 2'd0;
  localparam logic [1:0] DIR_OUT = 2'd1;

  localparam logic [1:0] CFG_OUTSIDE_ADDR = 2'd0;
  localparam logic [1:0] CFG_IDLE_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_FIRST_PORT   = 2'd2;
  localparam logic [1:0] CFG_LAST_PORT    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_DIR  = 3'd1,
    ST_NOT_TCP  = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_NO_ROOM  = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LATCH,
    DP_TICK,
    DP_RULE_LOAD,
    DP_SET_RES,
    DP_MAP_READ,
    DP_MAP_EVAL,
    DP_PORT_START,
    DP_PORT_READ,
    DP_PORT_EVAL,
    DP_RULE_READ,
    DP_RULE_EVAL,
    DP_CREATE,
    DP_UPDATE,
    DP_FREE_READ,
    DP_FREE_WRITE,
    DP_SWEEP_EVAL,
    DP_OUT_LOAD
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    status_t  res;
  } ntt_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] action;
    logic [1:0] direction;
    logic       is_tcp;
    logic       map_hit;
    logic       map_last;
    logic       free_found;
    logic       port_empty_range;
    logic       port_got;
    logic       port_last;
    logic       rule_hit;
    logic       rule_last;
    logic       rule_none;
    logic       rst_flag;
    logic       drop;
  } ntt_stat_t;

  typedef struct packed {
    logic [31:0] inside_addr;
    logic [15:0] inside_port;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [31:0] outside_addr;
    logic [15:0] outside_port;
    logic [1:0]  fin_seen;
    logic [31:0] inside_seq_end;
    logic [31:0] inside_ack;
    logic [31:0] outside_seq_end;
    logic [31:0] outside_ack;
    logic [31:0] touch_time;
  } map_entry_t;

  typedef struct packed {
    logic [31:0] outer_addr;
    logic [15:0] outer_port;
    logic [31:0] inner_addr;
    logic [15:0] inner_port;
  } rule_entry_t;

endpackage

@@ rtl/napt_translation_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napt_translation_table: NAPT mapping table for TCP over IPv4
// Channel   Handshake             Payload
// in        in_valid / in_ready   action .. ack_number (header summary)
// out       out_valid / out_ready status, new_address, new_port, mapping_freed
// cfg       cfg_we                cfg_index, cfg_data
// A packet scans the mapping memory slot by slot up to its match; a miss
// scans all MAP_ENTRIES slots, then one bitmap word or one rule at a time.
// A tick sweeps every slot and frees the ports of the entries it drops.
// After reset a clearing pass sweeps all 2048 words of the port bitmap.
// One request is worked at a time; the next is taken while a result waits.
// ----------------------------------------------------------------------------
module napt_translation_table
  import ntt_pkg::*;
#(
  parameter int MAP_ENTRIES  = MAP_ENTRIES_DEF,
  parameter int RULE_ENTRIES = RULE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  direction,
  input  logic        is_tcp,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_address,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [31:0] sequence_number,
  input  logic [31:0] ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] new_address,
  output logic [15:0] new_port,
  output logic        mapping_freed,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ntt_cmd_t  cmd;
  ntt_stat_t stat;

  ntt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ntt_dp #(
    .MAP_ENTRIES  (MAP_ENTRIES),
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .direction       (direction),
    .is_tcp          (is_tcp),
    .source_address  (source_address),
    .source_port     (source_port),
    .dest_address    (dest_address),
    .dest_port       (dest_port),
    .tcp_flag_bits   (tcp_flag_bits),
    .sequence_number (sequence_number),
    .ack_number      (ack_number),
    .status          (status),
    .new_address     (new_address),
    .new_port        (new_port),
    .mapping_freed   (mapping_freed)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block took a second request without finishing the first");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_DONE))
    else $error("result status out of range");

  a_pair_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (new_address == '0 && new_port == '0))
    else $error("rewritten pair given with a failing status");

  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mapping_freed) |-> (status == ST_OK))
    else $error("mapping freed without a translation");

endmodule

@@ rtl/ntt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_ctrl: sequencer of the NAPT translation table
// Walks each request through table scans, port search, rule search, entry
// update and release, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ntt_ctrl
  import ntt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ntt_stat_t stat,
  output ntt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_MREAD, S_MEVAL, S_MISS, S_PREAD, S_PEVAL,
    S_RREAD, S_REVAL, S_CREATE, S_UPDATE, S_FREE_RD, S_FREE_WR, S_SREAD,
    S_SEVAL, S_SFREE_RD, S_SFREE_WR, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   load_out;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.step   = DP_NOP;
    cmd.res    = ST_DONE;
    load_out   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.step = DP_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.step   = DP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.action)
          ACT_TICK: begin
            cmd.step   = DP_TICK;
            state_next = S_SREAD;
          end
          ACT_RULE: begin
            cmd.step   = DP_RULE_LOAD;
            state_next = S_FINISH;
          end
          ACT_PACKET: begin
            if (stat.direction[1]) begin
              cmd.step   = DP_SET_RES;
              cmd.res    = ST_BAD_DIR;
              state_next = S_FINISH;
            end else if (!stat.is_tcp) begin
              cmd.step   = DP_SET_RES;
              cmd.res    = ST_NOT_TCP;
              state_next = S_FINISH;
            end else begin
              state_next = S_MREAD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_MREAD: begin
        cmd.step   = DP_MAP_READ;
        state_next = S_MEVAL;
      end
      S_MEVAL: begin
        cmd.step = DP_MAP_EVAL;
        if (stat.map_hit) state_next = S_UPDATE;
        else if (stat.map_last) state_next = S_MISS;
        else state_next = S_MREAD;
      end
      S_MISS: begin
        if (stat.direction == DIR_OUT) begin
          if (!stat.free_found || stat.port_empty_range) begin
            cmd.step   = DP_SET_RES;
            cmd.res    = ST_NO_ROOM;
            state_next = S_FINISH;
          end else begin
            cmd.step   = DP_PORT_START;
            state_next = S_PREAD;
          end
        end else if (stat.rule_none) begin
          cmd.step   = DP_SET_RES;
          cmd.res    = ST_NO_MATCH;
          state_next = S_FINISH;
        end else begin
          state_next = S_RREAD;
        end
      end
      S_PREAD: begin
        cmd.step   = DP_PORT_READ;
        state_next = S_PEVAL;
      end
      S_PEVAL: begin
        cmd.step = DP_PORT_EVAL;
        if (stat.port_got) state_next = S_CREATE;
        else if (stat.port_last) state_next = S_FINISH;
        else state_next = S_PREAD;
      end
      S_RREAD: begin
        cmd.step   = DP_RULE_READ;
        state_next = S_REVAL;
      end
      S_REVAL: begin
        cmd.step = DP_RULE_EVAL;
        if (stat.rule_hit) state_next = stat.free_found ? S_CREATE : S_FINISH;
        else if (stat.rule_last) state_next = S_FINISH;
        else state_next = S_RREAD;
      end
      S_CREATE: begin
        cmd.step   = DP_CREATE;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.step   = DP_UPDATE;
        state_next = stat.rst_flag ? S_FREE_RD : S_FINISH;
      end
      S_FREE_RD: begin
        cmd.step   = DP_FREE_READ;
        state_next = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.step   = DP_FREE_WRITE;
        state_next = S_FINISH;
      end
      S_SREAD: begin
        cmd.step   = DP_MAP_READ;
        state_next = S_SEVAL;
      end
      S_SEVAL: begin
        cmd.step = DP_SWEEP_EVAL;
        if (stat.drop) state_next = S_SFREE_RD;
        else if (stat.map_last) state_next = S_FINISH;
        else state_next = S_SREAD;
      end
      S_SFREE_RD: begin
        cmd.step   = DP_FREE_READ;
        state_next = S_SFREE_WR;
      end
      S_SFREE_WR: begin
        cmd.step   = DP_FREE_WRITE;
        state_next = stat.map_last ? S_FINISH : S_SREAD;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.step   = DP_OUT_LOAD;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/ntt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_dp: datapath of the NAPT translation table
// Holds the mapping memory with its valid bits, the port-in-use bitmap, the
// rule memory, the clock of seconds, the configuration and the result.
// ----------------------------------------------------------------------------
module ntt_dp
  import ntt_pkg::*;
#(
  parameter int MAP_ENTRIES  = MAP_ENTRIES_DEF,
  parameter int RULE_ENTRIES = RULE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ntt_cmd_t    cmd,
  output ntt_stat_t   stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  action,
  input  logic [1:0]  direction,
  input  logic        is_tcp,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_address,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [31:0] sequence_number,
  input  logic [31:0] ack_number,
  output logic [2:0]  status,
  output logic [31:0] new_address,
  output logic [15:0] new_port,
  output logic        mapping_freed
);

  localparam int MAW = $clog2(MAP_ENTRIES);
  localparam int RIW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int RCW = $clog2(RULE_ENTRIES + 1);

  logic [31:0] outside_address;
  logic [15:0] idle_limit_seconds;
  logic [15:0] first_port;
  logic [15:0] last_port;

  logic [1:0]  act_l;
  logic [1:0]  dir_l;
  logic        tcp_l;
  logic [31:0] saddr;
  logic [15:0] sport;
  logic [31:0] daddr;
  logic [15:0] dport;
  logic [7:0]  flags;
  logic [31:0] seq;
  logic [31:0] ack;

  logic [31:0]            now_seconds;
  logic [MAP_ENTRIES-1:0] map_valid;
  map_entry_t             map_mem [MAP_ENTRIES];
  map_entry_t             map_q;
  logic                   vq;
  logic [MAW-1:0]         scan_idx;
  logic [MAW-1:0]         rd_idx;
  logic [MAW-1:0]         hit_idx;
  logic [MAW-1:0]         free_idx;
  logic                   free_found;

  rule_entry_t    rule_mem [RULE_ENTRIES];
  rule_entry_t    rule_q;
  logic [RCW-1:0] rule_k;
  logic [RCW-1:0] rule_count;

  logic [BM_WORD_W-1:0] bm_mem [BM_WORDS];
  logic [BM_WORD_W-1:0] bm_q;
  logic [BM_ADDR_W-1:0] clr_cnt;
  logic [BM_ADDR_W-1:0] pw;
  logic [15:0]          got_port;
  logic [15:0]          fport;

  status_t     pend_status;
  logic [31:0] pend_addr;
  logic [15:0] pend_port;
  logic        pend_freed;

  logic                 outbound;
  logic                 map_match;
  logic                 map_last;
  logic                 rule_hit;
  logic                 rule_last;
  logic                 rule_full;
  logic                 port_got;
  logic                 port_last;
  logic [BM_WORD_W-1:0] lo_mask;
  logic [BM_WORD_W-1:0] hi_mask;
  logic [BM_WORD_W-1:0] avail;
  logic [BM_BIT_W-1:0]  got_bit;
  logic                 finished;
  logic                 idle_out;
  logic                 drop;
  logic                 rst_flag;
  map_entry_t           upd;
  map_entry_t           created;

  logic                 bm_we;
  logic [BM_ADDR_W-1:0] bm_waddr;
  logic [BM_WORD_W-1:0] bm_wdata;
  logic                 bm_re;
  logic [BM_ADDR_W-1:0] bm_raddr;

  assign outbound  = (dir_l == DIR_OUT);
  assign map_last  = (rd_idx == MAW'(MAP_ENTRIES - 1));
  assign rst_flag  = (flags == FLAG_RST);
  assign map_match = vq && (outbound ?
      (map_q.peer_addr == daddr && map_q.peer_port == dport &&
       map_q.inside_addr == saddr && map_q.inside_port == sport) :
      (map_q.peer_addr == saddr && map_q.peer_port == sport &&
       map_q.outside_addr == daddr && map_q.outside_port == dport));

  assign rule_hit  = (rule_q.outer_addr == daddr) && (rule_q.outer_port == dport);
  assign rule_last = ((rule_k + RCW'(1)) == rule_count);
  assign rule_full = (rule_count == RCW'(RULE_ENTRIES));

  assign lo_mask = (pw == first_port[15:BM_BIT_W]) ?
                   ({BM_WORD_W{1'b1}} << first_port[BM_BIT_W-1:0]) : {BM_WORD_W{1'b1}};
  assign hi_mask = (pw == last_port[15:BM_BIT_W]) ?
                   ({BM_WORD_W{1'b1}} >> (~last_port[BM_BIT_W-1:0])) : {BM_WORD_W{1'b1}};
  assign avail   = ~bm_q & lo_mask & hi_mask &
                   ((pw == '0) ? ~BM_WORD_W'(1) : {BM_WORD_W{1'b1}});
  assign port_got  = |avail;
  assign port_last = (pw == last_port[15:BM_BIT_W]);

  always_comb begin
    got_bit = '0;
    for (int i = BM_WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) got_bit = BM_BIT_W'(i);
    end
  end

  assign finished = (map_q.fin_seen == 2'b11) &&
                    (map_q.inside_ack >= map_q.outside_seq_end) &&
                    (map_q.outside_ack >= map_q.inside_seq_end);
  assign idle_out = ((now_seconds - map_q.touch_time) > {16'd0, idle_limit_seconds});
  assign drop     = vq && (finished || idle_out);

  always_comb begin
    upd            = map_q;
    upd.touch_time = now_seconds;
    if (outbound) begin
      if (flags == FLAG_FIN) upd.fin_seen[0] = 1'b1;
      if (seq > map_q.inside_seq_end) upd.inside_seq_end = seq;
      if (ack > map_q.inside_ack) upd.inside_ack = ack;
    end else begin
      if (flags == FLAG_FIN) upd.fin_seen[1] = 1'b1;
      if (seq > map_q.outside_seq_end) upd.outside_seq_end = seq;
      if (ack > map_q.outside_ack) upd.outside_ack = ack;
    end
  end

  always_comb begin
    created                 = '0;
    created.touch_time      = now_seconds;
    if (outbound) begin
      created.inside_addr  = saddr;
      created.inside_port  = sport;
      created.peer_addr    = daddr;
      created.peer_port    = dport;
      created.outside_addr = outside_address;
      created.outside_port = got_port;
    end else begin
      created.inside_addr  = rule_q.inner_addr;
      created.inside_port  = rule_q.inner_port;
      created.peer_addr    = saddr;
      created.peer_port    = sport;
      created.outside_addr = rule_q.outer_addr;
      created.outside_port = rule_q.outer_port;
    end
  end

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = clr_cnt;
    bm_wdata = '0;
    bm_re    = 1'b0;
    bm_raddr = pw;
    case (cmd.step)
      DP_CLEAR: bm_we = 1'b1;
      DP_PORT_READ: bm_re = 1'b1;
      DP_PORT_EVAL: begin
        bm_we    = port_got;
        bm_waddr = pw;
        bm_wdata = bm_q | (BM_WORD_W'(1) << got_bit);
      end
      DP_FREE_READ: begin
        bm_re    = 1'b1;
        bm_raddr = fport[15:BM_BIT_W];
      end
      DP_FREE_WRITE: begin
        bm_we    = 1'b1;
        bm_waddr = fport[15:BM_BIT_W];
        bm_wdata = bm_q & ~(BM_WORD_W'(1) << fport[BM_BIT_W-1:0]);
      end
      default: bm_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.step == DP_UPDATE) map_mem[hit_idx] <= upd;
    if (cmd.step == DP_MAP_READ) map_q <= map_mem[scan_idx];
    else if (cmd.step == DP_CREATE) map_q <= created;
  end

  always_ff @(posedge clk) begin
    if (cmd.step == DP_RULE_LOAD && !rule_full) begin
      rule_mem[rule_count[RIW-1:0]] <= '{daddr, dport, saddr, sport};
    end
    if (cmd.step == DP_RULE_READ) rule_q <= rule_mem[rule_k[RIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outside_address    <= '0;
      idle_limit_seconds <= IDLE_LIMIT_RESET;
      first_port         <= FIRST_PORT_RESET;
      last_port          <= LAST_PORT_RESET;
      now_seconds        <= '0;
      map_valid          <= '0;
      rule_count         <= '0;
      clr_cnt            <= '0;
      free_found         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OUTSIDE_ADDR: outside_address <= cfg_data;
          CFG_IDLE_LIMIT:   idle_limit_seconds <= cfg_data[15:0];
          CFG_FIRST_PORT:   first_port <= cfg_data[15:0];
          CFG_LAST_PORT:    last_port <= cfg_data[15:0];
          default:          outside_address <= outside_address;
        endcase
      end
      case (cmd.step)
        DP_CLEAR: clr_cnt <= clr_cnt + BM_ADDR_W'(1);
        DP_LATCH: free_found <= 1'b0;
        DP_TICK: now_seconds <= now_seconds + 32'd1;
        DP_RULE_LOAD: begin
          if (!rule_full) rule_count <= rule_count + RCW'(1);
        end
        DP_MAP_EVAL: begin
          if (!map_match && !vq && !free_found) free_found <= 1'b1;
        end
        DP_CREATE: map_valid[free_idx] <= 1'b1;
        DP_UPDATE: begin
          if (rst_flag) map_valid[hit_idx] <= 1'b0;
        end
        DP_SWEEP_EVAL: begin
          if (drop) map_valid[rd_idx] <= 1'b0;
        end
        default: clr_cnt <= clr_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      DP_LATCH: begin
        act_l       <= action;
        dir_l       <= direction;
        tcp_l       <= is_tcp;
        saddr       <= source_address;
        sport       <= source_port;
        daddr       <= dest_address;
        dport       <= dest_port;
        flags       <= tcp_flag_bits;
        seq         <= sequence_number;
        ack         <= ack_number;
        scan_idx    <= '0;
        rule_k      <= '0;
        pend_status <= ST_DONE;
        pend_addr   <= '0;
        pend_port   <= '0;
        pend_freed  <= 1'b0;
      end
      DP_TICK: scan_idx <= '0;
      DP_RULE_LOAD: begin
        if (rule_full) pend_status <= ST_NO_ROOM;
      end
      DP_SET_RES: pend_status <= cmd.res;
      DP_MAP_READ: begin
        vq     <= map_valid[scan_idx];
        rd_idx <= scan_idx;
      end
      DP_MAP_EVAL: begin
        scan_idx <= scan_idx + MAW'(1);
        if (map_match) hit_idx <= rd_idx;
        else if (!vq && !free_found) free_idx <= rd_idx;
      end
      DP_PORT_START: pw <= first_port[15:BM_BIT_W];
      DP_PORT_EVAL: begin
        if (port_got) got_port <= {pw, got_bit};
        else if (port_last) pend_status <= ST_NO_ROOM;
        else pw <= pw + BM_ADDR_W'(1);
      end
      DP_RULE_EVAL: begin
        if (rule_hit) begin
          if (!free_found) pend_status <= ST_NO_ROOM;
        end else if (rule_last) begin
          pend_status <= ST_NO_MATCH;
        end else begin
          rule_k <= rule_k + RCW'(1);
        end
      end
      DP_CREATE: hit_idx <= free_idx;
      DP_UPDATE: begin
        pend_status <= ST_OK;
        pend_addr   <= outbound ? upd.outside_addr : upd.inside_addr;
        pend_port   <= outbound ? upd.outside_port : upd.inside_port;
        fport       <= upd.outside_port;
        pend_freed  <= rst_flag;
      end
      DP_SWEEP_EVAL: begin
        scan_idx <= scan_idx + MAW'(1);
        fport    <= map_q.outside_port;
      end
      DP_OUT_LOAD: begin
        status        <= pend_status;
        new_address   <= pend_addr;
        new_port      <= pend_port;
        mapping_freed <= pend_freed;
      end
      default: pend_freed <= pend_freed;
    endcase
  end

  always_comb begin
    stat                  = '0;
    stat.clear_done       = (clr_cnt == BM_ADDR_W'(BM_WORDS - 1));
    stat.action           = act_l;
    stat.direction        = dir_l;
    stat.is_tcp           = tcp_l;
    stat.map_hit          = map_match;
    stat.map_last         = map_last;
    stat.free_found       = free_found;
    stat.port_empty_range = (first_port > last_port);
    stat.port_got         = port_got;
    stat.port_last        = port_last;
    stat.rule_hit         = rule_hit;
    stat.rule_last        = rule_last;
    stat.rule_none        = (rule_count == '0);
    stat.rst_flag         = rst_flag;
    stat.drop             = drop;
  end

endmodule

@@ dv/napt_translation_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napt_translation_table_checker: translation predictor and result scoreboard
// Watches the request, result and register ports of the NAPT table. Each
// accepted request is run through a local copy of the mapping table, port
// bitmap and DNAT rules. The expected result is queued and compared field by
// field with the next result that the block hands out.
// ----------------------------------------------------------------------------
module napt_translation_table_checker
  import ntt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  direction,
  input  logic        is_tcp,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_address,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [31:0] sequence_number,
  input  logic [31:0] ack_number,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] new_address,
  input  logic [15:0] new_port,
  input  logic        mapping_freed,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          open_requests
);

  localparam int SLOTS = MAP_ENTRIES_DEF;
  localparam int RULES = RULE_ENTRIES_DEF;

  typedef struct packed {
    status_t     st;
    logic [31:0] addr;
    logic [15:0] port;
    logic        freed;
  } translation_t;

  translation_t pending_translations[$];

  bit          slot_used[SLOTS];
  map_entry_t  slot_tab[SLOTS];
  bit          port_taken[65536];
  rule_entry_t rule_tab[RULES];
  int          rule_fill;
  logic [31:0] clock_s;
  logic [31:0] nat_addr;
  logic [15:0] idle_limit;
  logic [15:0] port_lo;
  logic [15:0] port_hi;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic release_slot(input int i);
    port_taken[slot_tab[i].outside_port] = 1'b0;
    slot_used[i] = 1'b0;
  endtask

  function automatic bit flow_done(input int i);
    return slot_tab[i].fin_seen == 2'b11 &&
           slot_tab[i].inside_ack >= slot_tab[i].outside_seq_end &&
           slot_tab[i].outside_ack >= slot_tab[i].inside_seq_end;
  endfunction

  function automatic int lowest_open_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  task automatic open_slot(input int i, input logic [31:0] ia, input logic [15:0] ip,
                           input logic [31:0] ra, input logic [15:0] rp,
                           input logic [31:0] oa, input logic [15:0] op);
    slot_used[i] = 1'b1;
    slot_tab[i] = '0;
    slot_tab[i].inside_addr = ia;
    slot_tab[i].inside_port = ip;
    slot_tab[i].peer_addr = ra;
    slot_tab[i].peer_port = rp;
    slot_tab[i].outside_addr = oa;
    slot_tab[i].outside_port = op;
    slot_tab[i].touch_time = clock_s;
  endtask

  task automatic translate(output translation_t t);
    int hit;
    int slot;
    int got;
    int rule;
    hit = -1;
    t = '{st: ST_DONE, addr: '0, port: '0, freed: 1'b0};
    if (action == ACT_TICK) begin
      clock_s = clock_s + 32'd1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && (flow_done(i) ||
            (clock_s - slot_tab[i].touch_time) > {16'd0, idle_limit}))
          release_slot(i);
    end else if (action == ACT_RULE) begin
      if (rule_fill < RULES) begin
        rule_tab[rule_fill] = '{outer_addr: dest_address, outer_port: dest_port,
                                inner_addr: source_address, inner_port: source_port};
        rule_fill++;
      end else begin
        t.st = ST_NO_ROOM;
      end
    end else if (action == ACT_PACKET) begin
      if (direction != DIR_IN && direction != DIR_OUT) begin
        t.st = ST_BAD_DIR;
      end else if (!is_tcp) begin
        t.st = ST_NOT_TCP;
      end else if (direction == DIR_OUT) begin
        for (int i = 0; i < SLOTS && hit < 0; i++)
          if (slot_used[i] && slot_tab[i].peer_addr == dest_address &&
              slot_tab[i].peer_port == dest_port &&
              slot_tab[i].inside_addr == source_address &&
              slot_tab[i].inside_port == source_port)
            hit = i;
        if (hit < 0) begin
          slot = lowest_open_slot();
          got = 0;
          if (slot >= 0)
            for (int p = int'(port_lo); p <= int'(port_hi); p++)
              if (p != 0 && !port_taken[p]) begin
                got = p;
                break;
              end
          if (slot >= 0 && got != 0) begin
            port_taken[got] = 1'b1;
            open_slot(slot, source_address, source_port, dest_address, dest_port,
                      nat_addr, got[15:0]);
            hit = slot;
          end else begin
            t.st = ST_NO_ROOM;
          end
        end
        if (hit >= 0) begin
          slot_tab[hit].touch_time = clock_s;
          if (tcp_flag_bits == FLAG_FIN) slot_tab[hit].fin_seen[0] = 1'b1;
          if (sequence_number > slot_tab[hit].inside_seq_end)
            slot_tab[hit].inside_seq_end = sequence_number;
          if (ack_number > slot_tab[hit].inside_ack) slot_tab[hit].inside_ack = ack_number;
          t.addr = slot_tab[hit].outside_addr;
          t.port = slot_tab[hit].outside_port;
        end
      end else begin
        for (int i = 0; i < SLOTS && hit < 0; i++)
          if (slot_used[i] && slot_tab[i].peer_addr == source_address &&
              slot_tab[i].peer_port == source_port &&
              slot_tab[i].outside_addr == dest_address &&
              slot_tab[i].outside_port == dest_port)
            hit = i;
        if (hit < 0) begin
          rule = -1;
          for (int k = 0; k < rule_fill; k++)
            if (rule_tab[k].outer_addr == dest_address && rule_tab[k].outer_port == dest_port) begin
              rule = k;
              break;
            end
          if (rule < 0) begin
            t.st = ST_NO_MATCH;
          end else begin
            slot = lowest_open_slot();
            if (slot < 0) begin
              t.st = ST_NO_ROOM;
            end else begin
              open_slot(slot, rule_tab[rule].inner_addr, rule_tab[rule].inner_port,
                        source_address, source_port,
                        rule_tab[rule].outer_addr, rule_tab[rule].outer_port);
              hit = slot;
            end
          end
        end
        if (hit >= 0) begin
          slot_tab[hit].touch_time = clock_s;
          if (tcp_flag_bits == FLAG_FIN) slot_tab[hit].fin_seen[1] = 1'b1;
          if (sequence_number > slot_tab[hit].outside_seq_end)
            slot_tab[hit].outside_seq_end = sequence_number;
          if (ack_number > slot_tab[hit].outside_ack) slot_tab[hit].outside_ack = ack_number;
          t.addr = slot_tab[hit].inside_addr;
          t.port = slot_tab[hit].inside_port;
        end
      end
      if (hit >= 0) begin
        t.st = ST_OK;
        if (tcp_flag_bits == FLAG_RST) begin
          release_slot(hit);
          t.freed = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    translation_t t;
    if (rst) begin
      mismatches = 0;
      pending_translations.delete();
      open_requests = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (port_taken[i]) port_taken[i] = 1'b0;
      rule_fill = 0;
      clock_s = '0;
      nat_addr = '0;
      idle_limit = IDLE_LIMIT_RESET;
      port_lo = FIRST_PORT_RESET;
      port_hi = LAST_PORT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OUTSIDE_ADDR: nat_addr = cfg_data;
          CFG_IDLE_LIMIT:   idle_limit = cfg_data[15:0];
          CFG_FIRST_PORT:   port_lo = cfg_data[15:0];
          CFG_LAST_PORT:    port_hi = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_translations.size() == 0) begin
          report("unexpected result", {29'd0, status}, '0);
        end else begin
          t = pending_translations.pop_front();
          if (status !== t.st) report("status", {29'd0, status}, {29'd0, t.st});
          if (new_address !== t.addr) report("new_address", new_address, t.addr);
          if (new_port !== t.port) report("new_port", {16'd0, new_port}, {16'd0, t.port});
          if (mapping_freed !== t.freed)
            report("mapping_freed", {31'd0, mapping_freed}, {31'd0, t.freed});
        end
      end
      if (in_valid && in_ready) begin
        translate(t);
        pending_translations.push_back(t);
      end
      open_requests = pending_translations.size();
    end
  end

endmodule

@@ dv/napt_translation_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napt_translation_table_tb: stimulus and verdict for the NAPT table
// Loads DNAT rules, runs directed packets through every status, then random
// TCP flows in both directions with ticks, resets by RST and noise, across
// several port ranges, idle limits and outside addresses, including a full
// table, an exhausted port range and a long result-side stall.
// ----------------------------------------------------------------------------
module napt_translation_table_tb;
  import ntt_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 6000;

  typedef enum int {
    GEN_OUTBOUND, GEN_REPLY, GEN_TO_RULE, GEN_FRESH, GEN_TICK, GEN_RULE, GEN_NOISE
  } gen_kind_t;

  typedef struct {
    logic [1:0]  act;
    logic [1:0]  dir;
    logic        tcp;
    logic [31:0] sa;
    logic [15:0] sp;
    logic [31:0] da;
    logic [15:0] dp;
    logic [7:0]  fl;
    logic [31:0] sq;
    logic [31:0] ak;
  } request_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] action, direction;
  logic is_tcp;
  logic [31:0] source_address, dest_address, sequence_number, ack_number;
  logic [15:0] source_port, dest_port;
  logic [7:0] tcp_flag_bits;
  logic out_valid, out_ready;
  logic [2:0] status;
  logic [31:0] new_address;
  logic [15:0] new_port;
  logic mapping_freed;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int mismatches, open_requests;

  logic [31:0] host_addr[4], peer_addr[4], rule_addr[8];
  logic [15:0] host_port[4], peer_port[4], rule_port[8];
  logic [31:0] cur_outside;
  logic [15:0] cur_first;
  bit hold_off_req;
  int calm_items;
  int quiet_cycles;

  napt_translation_table dut (.*);

  napt_translation_table_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int r;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready = 1'b0;
        repeat (600) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready = 1'b1;
          repeat ($urandom_range(1, 30)) @(negedge clk);
        end else if (r < 95) begin
          out_ready = 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end else begin
          out_ready = 1'b0;
          repeat ($urandom_range(20, 120)) @(negedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_items = 40;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [7:0] pick_flags();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return FLAG_FIN;
    if (r < 18) return FLAG_RST;
    if (r < 28) return 8'($urandom);
    return 8'h10;
  endfunction

  function automatic logic [31:0] pick_number();
    return ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) : $urandom;
  endfunction

  task automatic send(input request_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = q.act;
    direction = q.dir;
    is_tcp = q.tcp;
    source_address = q.sa;
    source_port = q.sp;
    dest_address = q.da;
    dest_port = q.dp;
    tcp_flag_bits = q.fl;
    sequence_number = q.sq;
    ack_number = q.ak;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_OUTSIDE_ADDR) cur_outside = val;
    if (idx == CFG_FIRST_PORT) cur_first = val[15:0];
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (open_requests != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic new_pools();
    for (int i = 0; i < 4; i++) begin
      host_addr[i] = $urandom;
      host_port[i] = 16'($urandom);
      peer_addr[i] = $urandom;
      peer_port[i] = 16'($urandom);
    end
  endtask

  task automatic build(input gen_kind_t kind, output request_t q);
    int h, p, k;
    h = $urandom_range(0, 3);
    p = $urandom_range(0, 3);
    k = $urandom_range(0, 7);
    q = '{act: ACT_PACKET, dir: DIR_OUT, tcp: 1'b1, sa: host_addr[h], sp: host_port[h],
          da: peer_addr[p], dp: peer_port[p], fl: pick_flags(), sq: pick_number(),
          ak: pick_number()};
    case (kind)
      GEN_REPLY: begin
        q.dir = DIR_IN;
        q.sa = peer_addr[p];
        q.sp = peer_port[p];
        q.da = cur_outside;
        q.dp = cur_first + 16'($urandom_range(0, 5));
      end
      GEN_TO_RULE: begin
        q.dir = DIR_IN;
        q.sa = peer_addr[p];
        q.sp = peer_port[p];
        q.da = rule_addr[k];
        q.dp = rule_port[k];
      end
      GEN_FRESH: begin
        q.sa = $urandom;
        q.sp = 16'($urandom);
        q.fl = 8'h10;
      end
      GEN_TICK: q.act = ACT_TICK;
      GEN_RULE: q.act = ACT_RULE;
      GEN_NOISE: begin
        q.act = 2'($urandom);
        q.dir = 2'($urandom);
        q.tcp = 1'($urandom);
        q.sa = $urandom;
        q.sp = 16'($urandom);
        q.da = $urandom;
        q.dp = 16'($urandom);
        q.fl = 8'($urandom);
        q.sq = $urandom;
        q.ak = $urandom;
      end
      default: ;
    endcase
  endtask

  task automatic run_mix(input int n, input int fresh_pct);
    request_t q;
    gen_kind_t kind;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < fresh_pct) kind = GEN_FRESH;
      else if (r < 45) kind = GEN_OUTBOUND;
      else if (r < 70) kind = GEN_REPLY;
      else if (r < 80) kind = GEN_TO_RULE;
      else if (r < 86) kind = GEN_TICK;
      else if (r < 88) kind = GEN_RULE;
      else kind = GEN_NOISE;
      build(kind, q);
      send(q);
    end
  endtask

  initial begin
    request_t q;
    rst = 1'b1;
    in_valid = 1'b0;
    action = '0;
    direction = '0;
    is_tcp = 1'b0;
    source_address = '0;
    source_port = '0;
    dest_address = '0;
    dest_port = '0;
    tcp_flag_bits = '0;
    sequence_number = '0;
    ack_number = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_OUTSIDE_ADDR;
    cfg_data = '0;
    hold_off_req = 1'b0;
    calm_items = 0;
    cur_outside = '0;
    cur_first = FIRST_PORT_RESET;
    new_pools();
    for (int k = 0; k < 8; k++) begin
      rule_addr[k] = $urandom;
      rule_port[k] = 16'($urandom);
    end
    rule_addr[0] = '1;
    rule_port[0] = '1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    build(GEN_OUTBOUND, q);
    q.dir = 2'd2;
    q.tcp = 1'b0;
    send(q);
    q.dir = 2'd3;
    q.tcp = 1'b1;
    send(q);
    q.dir = DIR_OUT;
    q.tcp = 1'b0;
    send(q);
    build(GEN_REPLY, q);
    send(q);
    q.act = 2'd3;
    send(q);
    for (int k = 0; k < 9; k++) begin
      build(GEN_RULE, q);
      q.da = rule_addr[k % 8];
      q.dp = rule_port[k % 8];
      q.sa = (k == 0) ? 32'd0 : host_addr[k % 4];
      q.sp = (k == 0) ? 16'd0 : host_port[k % 4];
      send(q);
    end
    q = '{act: ACT_PACKET, dir: DIR_OUT, tcp: 1'b1, sa: host_addr[0], sp: host_port[0],
          da: peer_addr[0], dp: peer_port[0], fl: 8'h02, sq: 32'd0, ak: 32'd0};
    send(q);
    q.fl = FLAG_FIN;
    q.sq = '1;
    send(q);
    q = '{act: ACT_PACKET, dir: DIR_IN, tcp: 1'b1, sa: peer_addr[0], sp: peer_port[0],
          da: 32'd0, dp: FIRST_PORT_RESET, fl: FLAG_FIN, sq: 32'd0, ak: '1};
    send(q);
    build(GEN_TICK, q);
    send(q);
    q = '{act: ACT_PACKET, dir: DIR_IN, tcp: 1'b1, sa: peer_addr[1], sp: peer_port[1],
          da: rule_addr[0], dp: rule_port[0], fl: 8'h02, sq: 32'd5, ak: 32'd0};
    send(q);
    q = '{act: ACT_PACKET, dir: DIR_OUT, tcp: 1'b1, sa: host_addr[1], sp: host_port[1],
          da: peer_addr[1], dp: peer_port[1], fl: FLAG_RST, sq: 32'd1, ak: 32'd1};
    send(q);
    q = '{act: ACT_PACKET, dir: DIR_IN, tcp: 1'b1, sa: peer_addr[1], sp: peer_port[1],
          da: rule_addr[0], dp: rule_port[0], fl: FLAG_RST, sq: 32'd6, ak: 32'd0};
    send(q);
    q = '{act: ACT_PACKET, dir: DIR_OUT, tcp: 1'b1, sa: '1, sp: '1, da: '1, dp: '1,
          fl: '1, sq: '1, ak: '1};
    send(q);

    settle();
    write_cfg(CFG_OUTSIDE_ADDR, '1);
    write_cfg(CFG_IDLE_LIMIT, 32'd0);
    write_cfg(CFG_FIRST_PORT, 32'd0);
    write_cfg(CFG_LAST_PORT, 32'd3);
    new_pools();
    run_mix(150, 0);

    settle();
    write_cfg(CFG_OUTSIDE_ADDR, $urandom);
    write_cfg(CFG_IDLE_LIMIT, 32'hFFFF);
    write_cfg(CFG_FIRST_PORT, 32'd1024);
    write_cfg(CFG_LAST_PORT, 32'd2047);
    run_mix(300, 90);

    settle();
    write_cfg(CFG_IDLE_LIMIT, 32'd0);
    build(GEN_TICK, q);
    send(q);
    run_mix(30, 0);

    settle();
    hold_off_req = 1'b1;
    write_cfg(CFG_OUTSIDE_ADDR, $urandom);
    write_cfg(CFG_IDLE_LIMIT, 32'd3);
    write_cfg(CFG_FIRST_PORT, 32'hFFFA);
    write_cfg(CFG_LAST_PORT, 32'hFFFF);
    new_pools();
    run_mix(300, 10);

    settle();
    write_cfg(CFG_FIRST_PORT, 32'd2000);
    write_cfg(CFG_LAST_PORT, 32'd1000);
    run_mix(40, 0);

    settle();
    write_cfg(CFG_OUTSIDE_ADDR, $urandom);
    write_cfg(CFG_IDLE_LIMIT, 32'd60);
    write_cfg(CFG_FIRST_PORT, 32'd1024);
    write_cfg(CFG_LAST_PORT, 32'hFFFF);
    new_pools();
    run_mix(110, 5);

    in_valid = 1'b0;
    while (open_requests != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && open_requests == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
